// ----- hw/rtl/srf_pkg.sv -----
// Shared types, codes and default sizes for the sync retry failover controller.
package srf_pkg;

  localparam int INDEX_WIDTH_DEFAULT = 8;
  localparam int RETRY_WIDTH_DEFAULT = 8;
  localparam int SEQ_WIDTH_DEFAULT   = 32;

  localparam int MAX_INDEX_RESET = 3;
  localparam int MAX_RETRY_RESET = 3;

  localparam int OPCODE_WIDTH    = 3;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [1:0] {
    ST_HALTED   = 2'd0,
    ST_DOWNLOAD = 2'd1,
    ST_FAILED   = 2'd2,
    ST_SYNCED   = 2'd3
  } session_t;

  typedef enum logic [1:0] {
    CTL_IDLE   = 2'd0,
    CTL_DIVIDE = 2'd1,
    CTL_WRITE  = 2'd2
  } ctl_t;

  localparam logic [OPCODE_WIDTH-1:0] OP_HALT     = 3'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_SYNC     = 3'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_REPLY    = 3'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_TIMEOUT  = 3'd3;
  localparam logic [OPCODE_WIDTH-1:0] OP_SET_NEXT = 3'd4;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  localparam logic [1:0] RES_UNEXPECTED = 2'd0;
  localparam logic [1:0] RES_DISCARDED  = 2'd1;
  localparam logic [1:0] RES_ACCEPTED   = 2'd2;
  localparam logic [1:0] RES_NONE       = 2'd3;

  localparam logic REPLY_COMPLETE = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_INDEX = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_RETRY = 2'd1;

endpackage

// ----- hw/rtl/srf_mod_unit.sv -----
// Bit-serial restoring remainder unit for endpoint index wrapping.
module srf_mod_unit #(
  parameter int INDEX_WIDTH = srf_pkg::INDEX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [INDEX_WIDTH:0]   dividend,
  input  logic [INDEX_WIDTH:0]   divisor,
  output logic                   done,
  output logic [INDEX_WIDTH-1:0] remainder
);

  localparam int STEPS = INDEX_WIDTH + 1;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [INDEX_WIDTH:0] dvd;
  logic [INDEX_WIDTH:0] rem;
  logic [INDEX_WIDTH+1:0] trial;
  logic [INDEX_WIDTH:0] rem_next;

  always_comb begin
    trial = {rem, dvd[INDEX_WIDTH]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = INDEX_WIDTH'(trial - {1'b0, divisor}) == '0 ? '0 :
                 (INDEX_WIDTH+1)'(trial - {1'b0, divisor});
    end else begin
      rem_next = (INDEX_WIDTH+1)'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[INDEX_WIDTH-1:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem[INDEX_WIDTH-1:0];

endmodule

// ----- hw/rtl/sync_retry_failover_fsm_unit.sv -----
// Top level of the snapshot sync session controller with endpoint failover.
//
// Events arrive as beats on the s_axis channel; each accepted beat yields
// exactly one result beat on m_axis, carrying the session state after the
// event and the endpoint, sync and timer commands it causes.
// Registers max_index and max_retry are written through the cfg channel,
// which is always ready; writes are meant for times when no event is open.
// Events that rotate or reset the next endpoint index (halt from any state
// but halted, sync from failed, a retried timeout, set next index) run a
// shared bit-serial remainder unit in the divide step, before the write step
// that loads the result into the output register; all other events go from
// idle straight to the write step. One event is worked on at a time; the
// input stays not ready until its result sits in the output register.
// A result waiting in the output register does not stop the next beat from
// being accepted; that event's result waits until the receiver takes the
// earlier one. Reset returns the session to halted, both registers to 3,
// the next index to 1 and all counters to zero.
module sync_retry_failover_fsm_unit #(
  parameter int INDEX_WIDTH = srf_pkg::INDEX_WIDTH_DEFAULT,
  parameter int RETRY_WIDTH = srf_pkg::RETRY_WIDTH_DEFAULT,
  parameter int SEQ_WIDTH   = srf_pkg::SEQ_WIDTH_DEFAULT,
  localparam int IN_BITS    = srf_pkg::OPCODE_WIDTH + INDEX_WIDTH + SEQ_WIDTH,
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 9 + 4 * INDEX_WIDTH + RETRY_WIDTH + SEQ_WIDTH,
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8,
  localparam int CFG_DATA_W = (INDEX_WIDTH > RETRY_WIDTH) ? INDEX_WIDTH : RETRY_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // opcode, index_value, reply_seqn
  input  logic [IN_DATA_W-1:0]                 s_axis_tdata,
  // reply_kind
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // machine_state, current_index, upcoming_index, retry_count, seq_number,
  // close_valid, close_index, open_valid, open_index, sync_valid, timer_cmd,
  // reply_result
  output logic [OUT_DATA_W-1:0]                m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  logic [INDEX_WIDTH-1:0] max_index;
  logic [RETRY_WIDTH-1:0] max_retry;

  srf_pkg::session_t      sess;
  logic [INDEX_WIDTH-1:0] active;
  logic [INDEX_WIDTH-1:0] following;
  logic [RETRY_WIDTH-1:0] retries;
  logic [SEQ_WIDTH-1:0]   seq_count;

  logic                   close_v;
  logic [INDEX_WIDTH-1:0] close_i;
  logic                   open_v;
  logic [INDEX_WIDTH-1:0] open_i;
  logic                   sync_v;
  logic [1:0]             timer;
  logic [1:0]             result;

  srf_pkg::session_t      sess_next;
  logic [INDEX_WIDTH-1:0] active_next;
  logic [RETRY_WIDTH-1:0] retries_next;
  logic [SEQ_WIDTH-1:0]   seq_count_next;
  logic                   close_v_next;
  logic [INDEX_WIDTH-1:0] close_i_next;
  logic                   open_v_next;
  logic [INDEX_WIDTH-1:0] open_i_next;
  logic                   sync_v_next;
  logic [1:0]             timer_next;
  logic [1:0]             result_next;
  logic                   wrap_req;
  logic [INDEX_WIDTH:0]   wrap_arg;

  srf_pkg::ctl_t          ctl;
  srf_pkg::ctl_t          ctl_next;
  logic                   accept;
  logic                   mod_start;
  logic                   mod_done;
  logic [INDEX_WIDTH-1:0] mod_rem;
  logic [INDEX_WIDTH:0]   modulus;
  logic                   out_load;

  logic [srf_pkg::OPCODE_WIDTH-1:0] op;
  logic [INDEX_WIDTH-1:0] idx_in;
  logic [SEQ_WIDTH-1:0]   seq_in;
  logic                   kind;
  logic [RETRY_WIDTH:0]   retry_plus;

  assign op     = s_axis_tdata[srf_pkg::OPCODE_WIDTH-1:0];
  assign idx_in = s_axis_tdata[srf_pkg::OPCODE_WIDTH +: INDEX_WIDTH];
  assign seq_in = s_axis_tdata[srf_pkg::OPCODE_WIDTH + INDEX_WIDTH +: SEQ_WIDTH];
  assign kind   = s_axis_tuser[0];

  assign cfg_ready  = 1'b1;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign modulus    = {1'b0, max_index} + 1'b1;
  assign retry_plus = {1'b0, retries} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_index <= INDEX_WIDTH'(srf_pkg::MAX_INDEX_RESET);
      max_retry <= RETRY_WIDTH'(srf_pkg::MAX_RETRY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srf_pkg::CFG_MAX_INDEX: max_index <= cfg_data[INDEX_WIDTH-1:0];
        srf_pkg::CFG_MAX_RETRY: max_retry <= cfg_data[RETRY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sess_next      = sess;
    active_next    = active;
    retries_next   = retries;
    seq_count_next = seq_count;
    close_v_next   = 1'b0;
    close_i_next   = '0;
    open_v_next    = 1'b0;
    open_i_next    = '0;
    sync_v_next    = 1'b0;
    timer_next     = srf_pkg::TMR_NONE;
    result_next    = srf_pkg::RES_NONE;
    wrap_req       = 1'b0;
    wrap_arg       = '0;
    unique case (op)
      srf_pkg::OP_HALT: begin
        if (sess != srf_pkg::ST_HALTED) begin
          if (sess != srf_pkg::ST_FAILED) begin
            close_v_next = 1'b1;
            close_i_next = active;
          end
          timer_next     = srf_pkg::TMR_STOP;
          seq_count_next = '0;
          retries_next   = '0;
          active_next    = '0;
          sess_next      = srf_pkg::ST_HALTED;
          wrap_req       = 1'b1;
          wrap_arg       = (INDEX_WIDTH+1)'(1);
        end
      end
      srf_pkg::OP_SYNC: begin
        if (sess != srf_pkg::ST_DOWNLOAD) begin
          retries_next = '0;
          if (sess != srf_pkg::ST_SYNCED) begin
            open_v_next = 1'b1;
            open_i_next = active;
            if (sess == srf_pkg::ST_FAILED) begin
              active_next = following;
              open_i_next = following;
              wrap_req    = 1'b1;
              wrap_arg    = {1'b0, following} + 1'b1;
            end
          end
          timer_next     = srf_pkg::TMR_START;
          seq_count_next = seq_count + 1'b1;
          sess_next      = srf_pkg::ST_DOWNLOAD;
          sync_v_next    = 1'b1;
        end
      end
      srf_pkg::OP_REPLY: begin
        if (sess != srf_pkg::ST_DOWNLOAD) begin
          result_next = srf_pkg::RES_UNEXPECTED;
        end else if (idx_in != active || seq_in != seq_count) begin
          result_next = srf_pkg::RES_DISCARDED;
        end else begin
          result_next = srf_pkg::RES_ACCEPTED;
          if (kind == srf_pkg::REPLY_COMPLETE) begin
            timer_next = srf_pkg::TMR_STOP;
            sess_next  = srf_pkg::ST_SYNCED;
          end else begin
            timer_next = srf_pkg::TMR_START;
          end
        end
      end
      srf_pkg::OP_TIMEOUT: begin
        if (sess == srf_pkg::ST_DOWNLOAD) begin
          close_v_next = 1'b1;
          close_i_next = active;
          if (retry_plus > {1'b0, max_retry}) begin
            timer_next = srf_pkg::TMR_STOP;
            sess_next  = srf_pkg::ST_FAILED;
          end else begin
            retries_next   = retry_plus[RETRY_WIDTH-1:0];
            active_next    = following;
            open_v_next    = 1'b1;
            open_i_next    = following;
            timer_next     = srf_pkg::TMR_START;
            seq_count_next = seq_count + 1'b1;
            sync_v_next    = 1'b1;
            wrap_req       = 1'b1;
            wrap_arg       = {1'b0, following} + 1'b1;
          end
        end
      end
      srf_pkg::OP_SET_NEXT: begin
        wrap_req = 1'b1;
        wrap_arg = {1'b0, idx_in};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= srf_pkg::CTL_IDLE;
    end else begin
      ctl <= ctl_next;
    end
  end

  always_comb begin
    ctl_next      = ctl;
    s_axis_tready = 1'b0;
    mod_start     = 1'b0;
    out_load      = 1'b0;
    unique case (ctl)
      srf_pkg::CTL_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mod_start = wrap_req;
          ctl_next  = wrap_req ? srf_pkg::CTL_DIVIDE : srf_pkg::CTL_WRITE;
        end
      end
      srf_pkg::CTL_DIVIDE: begin
        if (mod_done) begin
          ctl_next = srf_pkg::CTL_WRITE;
        end
      end
      srf_pkg::CTL_WRITE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          ctl_next = srf_pkg::CTL_IDLE;
        end
      end
      default: ctl_next = srf_pkg::CTL_IDLE;
    endcase
  end

  srf_mod_unit #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (wrap_arg),
    .divisor   (modulus),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sess      <= srf_pkg::ST_HALTED;
      active    <= '0;
      following <= INDEX_WIDTH'(1);
      retries   <= '0;
      seq_count <= '0;
    end else if (accept) begin
      sess      <= sess_next;
      active    <= active_next;
      retries   <= retries_next;
      seq_count <= seq_count_next;
    end else if (ctl == srf_pkg::CTL_DIVIDE && mod_done) begin
      following <= mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      close_v <= close_v_next;
      close_i <= close_i_next;
      open_v  <= open_v_next;
      open_i  <= open_i_next;
      sync_v  <= sync_v_next;
      timer   <= timer_next;
      result  <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_DATA_W'({result, timer, sync_v, open_i, open_v, close_i,
                                   close_v, seq_count, retries, following, active,
                                   sess});
    end
  end

`ifndef SYNTH
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> ctl == srf_pkg::CTL_DIVIDE)
    else $error("remainder unit finished outside the divide step");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> ctl == srf_pkg::CTL_IDLE && s_axis_tvalid)
    else $error("remainder unit started without an accepted event");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl == srf_pkg::CTL_DIVIDE && mod_done |=> following <= max_index)
    else $error("wrapped next index is beyond the highest endpoint");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("result beat overwritten before it was taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctl != srf_pkg::CTL_IDLE)
    else $error("controller returned to idle without writing a result");
`endif

endmodule
